// ===== rtl/bpc_pkg.sv =====
package bpc_pkg;

    typedef enum logic [2:0] {
        MODE_BTN0 = 3'd0,
        MODE_BTN1 = 3'd1,
        MODE_BTN2 = 3'd2,
        MODE_WAIT = 3'd3,
        MODE_IDLE = 3'd4
    } bpc_mode_t;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHORT = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;
    localparam logic [1:0] EV_RESET = 2'd3;

    localparam logic       CFG_LONG_PRESS  = 1'b0;
    localparam logic       CFG_RESET_PRESS = 1'b1;

    localparam logic [15:0] LONG_PRESS_RST  = 16'd1000;
    localparam logic [15:0] RESET_PRESS_RST = 16'd5000;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [2:0]  pressed_mask;
    } bpc_in_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [1:0] event_button;
    } bpc_out_t;

    // state update produced by the classifier for one poll
    typedef struct packed {
        bpc_mode_t mode;
        logic      latch;
    } bpc_upd_t;

endpackage

// ===== rtl/bpc_classify.sv =====
module bpc_classify (
    input  bpc_pkg::bpc_mode_t mode,
    input  logic [31:0]        start_ms,
    input  logic [15:0]        long_press_ms,
    input  logic [15:0]        reset_press_ms,
    input  bpc_pkg::bpc_in_t   poll,
    output bpc_pkg::bpc_upd_t  upd,
    output bpc_pkg::bpc_out_t  result
);
    import bpc_pkg::*;

    logic [31:0] elapsed;
    logic        held;
    logic        is_long;
    logic        is_reset;

    // wrapping difference
    assign elapsed  = poll.now_ms - start_ms;
    assign held     = poll.pressed_mask[mode[1:0]];
    assign is_long  = elapsed > {16'd0, long_press_ms};
    assign is_reset = (mode == MODE_BTN2) && (elapsed > {16'd0, reset_press_ms});

    // next state
    always_comb
    begin
        upd.mode  = mode;
        upd.latch = 1'b0;
        case (mode)
            MODE_WAIT:
            begin
                if (poll.pressed_mask == 3'd0)
                begin
                    upd.mode = MODE_IDLE;
                end
            end
            MODE_BTN0, MODE_BTN1, MODE_BTN2:
            begin
                if (!held)
                begin
                    upd.mode = MODE_IDLE;
                end
                else if (is_reset || is_long)
                begin
                    upd.mode = MODE_WAIT;
                end
            end
            default:
            begin
                // idle: latch the lowest pressed button
                upd.latch = (poll.pressed_mask != 3'd0);
                if (poll.pressed_mask[0])
                begin
                    upd.mode = MODE_BTN0;
                end
                else if (poll.pressed_mask[1])
                begin
                    upd.mode = MODE_BTN1;
                end
                else if (poll.pressed_mask[2])
                begin
                    upd.mode = MODE_BTN2;
                end
                else
                begin
                    upd.mode = MODE_IDLE;
                end
            end
        endcase
    end

    // outputs
    always_comb
    begin
        result.event_kind   = EV_NONE;
        result.event_button = 2'd0;
        case (mode)
            MODE_BTN0, MODE_BTN1, MODE_BTN2:
            begin
                if (is_reset)
                begin
                    result.event_kind   = EV_RESET;
                    result.event_button = mode[1:0];
                end
                else if (is_long)
                begin
                    result.event_kind   = EV_LONG;
                    result.event_button = mode[1:0];
                end
                else if (!held)
                begin
                    result.event_kind   = EV_SHORT;
                    result.event_button = mode[1:0];
                end
            end
            default:
            begin
                result.event_kind   = EV_NONE;
                result.event_button = 2'd0;
            end
        endcase
    end

endmodule

// ===== rtl/button_press_classifier.sv =====
// Channel  Direction  Handshake             Word
// in       input      in_valid / in_ready   in_data   (now_ms, pressed_mask)
// out      output     out_valid / out_ready out_data  (event_kind, event_button)
// cfg      input      cfg_we                cfg_index, cfg_data
//
// One poll per cycle unless out stalls; out_valid is the result register's flag.
// The press state advances as a poll moves from the input register into the
// result register; that single step (one 32-bit subtract and two compares) sets
// the rate. Reset clears both word registers to empty, the state to idle and
// the thresholds to 1000 and 5000 ms. A stalled output holds its word while the
// input register still takes one more poll.
module button_press_classifier (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bpc_pkg::bpc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bpc_pkg::bpc_out_t out_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data
);
    import bpc_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    bpc_in_t     in_word_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    bpc_out_t    out_word_reg;
    bpc_mode_t   mode_reg;
    logic [31:0] start_reg;
    logic [15:0] long_press_reg;
    logic [15:0] reset_press_reg;

    logic        advance;
    logic        in_take;
    bpc_upd_t    upd;
    bpc_out_t    result;

    bpc_classify u_classify (
        .mode           (mode_reg),
        .start_ms       (start_reg),
        .long_press_ms  (long_press_reg),
        .reset_press_ms (reset_press_reg),
        .poll           (in_word_reg),
        .upd            (upd),
        .result         (result)
    );

    assign advance        = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !in_valid_reg || advance;
    assign in_take        = in_valid && in_ready;
    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            mode_reg        <= MODE_IDLE;
            start_reg       <= 32'd0;
            long_press_reg  <= LONG_PRESS_RST;
            reset_press_reg <= RESET_PRESS_RST;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg <= upd.mode;
                if (upd.latch)
                begin
                    start_reg <= in_word_reg.now_ms;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LONG_PRESS:  long_press_reg  <= cfg_data;
                    CFG_RESET_PRESS: reset_press_reg <= cfg_data;
                    default:         long_press_reg  <= long_press_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg <= in_data;
        end
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    // entering wait means a long or reset press was just reported
    a_wait_reported: assert property (@(posedge clk) disable iff (!rst_n)
        advance && upd.mode == MODE_WAIT && mode_reg != MODE_WAIT
        |-> result.event_kind == EV_LONG || result.event_kind == EV_RESET)
        else $error("entered wait without a report");

    a_reset_btn2: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.event_kind == EV_RESET |-> mode_reg == MODE_BTN2)
        else $error("reset press on a button other than 2");

    a_none_btn0: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.event_kind == EV_NONE |-> result.event_button == 2'd0)
        else $error("empty word names a button");

    a_latch_time: assert property (@(posedge clk) disable iff (!rst_n)
        advance && upd.latch |=> start_reg == $past(in_word_reg.now_ms))
        else $error("press start time not latched");

    a_report_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.event_kind != EV_NONE
        |=> mode_reg == MODE_IDLE || mode_reg == MODE_WAIT)
        else $error("still latched after a report");

endmodule

// ===== dv/button_press_classifier_tb.sv =====
`timescale 1ns / 100ps

module button_press_classifier_tb;

    import bpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP     = 20;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    bpc_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    bpc_out_t out_data;
    logic     cfg_we;
    logic     cfg_index;
    logic [15:0] cfg_data;

    // local copy of the press state and thresholds
    bpc_mode_t   press_state = MODE_IDLE;
    logic [31:0] press_start = '0;
    logic [15:0] long_limit  = LONG_PRESS_RST;
    logic [15:0] reset_limit = RESET_PRESS_RST;

    bpc_out_t    expected_events[$];
    int          error_count   = 0;
    int          polls_sent    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          stall_request = 0;
    int unsigned cycle_count   = 0;

    button_press_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bpc_out_t classify_poll(bpc_in_t poll);
        bpc_out_t    ev;
        logic [1:0]  btn;
        logic [31:0] held_ms;
        logic        over_reset;
        logic        over_long;
        ev.event_kind   = EV_NONE;
        ev.event_button = 2'd0;
        btn = press_state[1:0];
        case (press_state)
            MODE_WAIT:
            begin
                if (poll.pressed_mask == 3'b000)
                    press_state = MODE_IDLE;
            end
            MODE_BTN0, MODE_BTN1, MODE_BTN2:
            begin
                held_ms    = poll.now_ms - press_start;
                over_reset = (press_state == MODE_BTN2) && (held_ms > {16'd0, reset_limit});
                over_long  = held_ms > {16'd0, long_limit};
                if (!poll.pressed_mask[btn])
                begin
                    ev.event_kind   = over_reset ? EV_RESET : (over_long ? EV_LONG : EV_SHORT);
                    ev.event_button = btn;
                    press_state     = MODE_IDLE;
                end
                else if (over_reset || over_long)
                begin
                    ev.event_kind   = over_reset ? EV_RESET : EV_LONG;
                    ev.event_button = btn;
                    press_state     = MODE_WAIT;
                end
            end
            default:
            begin
                // latch the lowest pressed button
                if (poll.pressed_mask[0])
                begin
                    press_state = MODE_BTN0;
                    press_start = poll.now_ms;
                end
                else if (poll.pressed_mask[1])
                begin
                    press_state = MODE_BTN1;
                    press_start = poll.now_ms;
                end
                else if (poll.pressed_mask[2])
                begin
                    press_state = MODE_BTN2;
                    press_start = poll.now_ms;
                end
                else
                    press_state = MODE_IDLE;
            end
        endcase
        return ev;
    endfunction

    // Called just after a rising edge; returns just after the edge that took the word.
    task automatic send_poll(input logic [31:0] now, input logic [2:0] mask);
        int      gap;
        bpc_in_t poll;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll.now_ms       = now;
        poll.pressed_mask = mask;
        in_valid <= 1'b1;
        in_data  <= poll;
        do
            @(negedge clk);
        while (!in_ready);
        expected_events.push_back(classify_poll(poll));
        polls_sent++;
        @(posedge clk);
    endtask

    task automatic wait_until_settled();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [15:0] long_ms, input logic [15:0] reset_ms);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LONG_PRESS;
        cfg_data  <= long_ms;
        @(posedge clk);
        cfg_index <= CFG_RESET_PRESS;
        cfg_data  <= reset_ms;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        long_limit  = long_ms;
        reset_limit = reset_ms;
    endtask

    function automatic logic [31:0] pick_elapsed();
        case ($urandom_range(6))
            0: return {16'd0, long_limit};
            1: return {16'd0, long_limit} + 32'd1;
            2: return {16'd0, reset_limit};
            3: return {16'd0, reset_limit} + 32'd1;
            4: return $urandom();
            default: return $urandom_range(0, int'(long_limit) + int'(reset_limit) + 2);
        endcase
    endfunction

    // latch, hold a few polls, release, sometimes let go of everything
    task automatic press_sequence();
        logic [31:0] start;
        logic [2:0]  latch_mask;
        logic [2:0]  mask;
        int          btn;
        start = $urandom();
        if ($urandom_range(1))
            latch_mask = 3'b001 << $urandom_range(2);
        else
            latch_mask = 3'($urandom_range(1, 7));
        btn = latch_mask[0] ? 0 : (latch_mask[1] ? 1 : 2);
        send_poll(start, latch_mask);
        repeat ($urandom_range(0, 3))
        begin
            mask      = 3'($urandom_range(0, 7));
            mask[btn] = 1'b1;
            send_poll(start + pick_elapsed(), mask);
        end
        mask      = 3'($urandom_range(0, 7));
        mask[btn] = 1'b0;
        send_poll(start + pick_elapsed(), mask);
        if ($urandom_range(1))
            send_poll($urandom(), 3'b000);
    endtask

    task automatic test_directed_presses();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_poll(32'd100, 3'b000);
        send_poll(32'd200, 3'b001);
        send_poll(32'd700, 3'b001);
        send_poll(32'd1200, 3'b000);       // exactly at the long threshold: short
        send_poll(32'd2000, 3'b110);
        send_poll(32'd2500, 3'b100);       // button 2 held but ignored
        send_poll(32'd3000, 3'b111);
        send_poll(32'd4001, 3'b111);       // long while held, then wait
        send_poll(32'd9000, 3'b011);
        send_poll(32'd9100, 3'b000);
        send_poll(32'hFFFF_FE00, 3'b100);
        send_poll(32'h0000_0100, 3'b100);  // elapsed across the wrap
        send_poll(32'h0000_1000, 3'b100);
        send_poll(32'h0000_2000, 3'b000);
        send_poll(32'd10000, 3'b100);
        send_poll(32'd15001, 3'b000);      // both exceeded: reset wins
        send_poll(32'd20000, 3'b100);
        send_poll(32'd25001, 3'b100);
        send_poll(32'd25002, 3'b000);
        send_poll(32'd30000, 3'b100);
        send_poll(32'd31500, 3'b000);
        send_poll(32'hFFFF_FFFF, 3'b010);  // latch poll reports nothing
        send_poll(32'h0000_0000, 3'b000);
        wait_until_settled();
    endtask

    task automatic test_threshold_extremes();
        set_thresholds(16'd0, 16'd0);
        send_poll(32'd100, 3'b100);
        send_poll(32'd100, 3'b100);
        send_poll(32'd101, 3'b100);
        send_poll(32'd200, 3'b000);
        send_poll(32'd300, 3'b001);
        send_poll(32'd301, 3'b000);
        send_poll(32'd400, 3'b001);
        send_poll(32'd400, 3'b000);
        wait_until_settled();
        set_thresholds(16'hFFFF, 16'hFFFF);
        send_poll(32'd0, 3'b001);
        send_poll(32'd65535, 3'b001);
        send_poll(32'd65536, 3'b001);
        send_poll(32'd70000, 3'b000);
        send_poll(32'd1000, 3'b100);
        send_poll(32'd66536, 3'b000);
        wait_until_settled();
        set_thresholds(16'hFFFF, 16'd0);
        send_poll(32'd5, 3'b100);
        send_poll(32'd6, 3'b000);
        wait_until_settled();
        set_thresholds(16'd0, 16'hFFFF);
        send_poll(32'd5, 3'b100);
        send_poll(32'd6, 3'b100);
        send_poll(32'd7, 3'b000);
        wait_until_settled();
    endtask

    task automatic test_random_polls(input int count, input int send_pct, input int recv_pct);
        int target;
        target        = polls_sent + count;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (polls_sent < target)
        begin
            case ($urandom_range(7))
                0: set_thresholds(16'd0, 16'hFFFF);
                1: set_thresholds(16'hFFFF, 16'd0);
                default: set_thresholds(16'($urandom_range(0, 400)),
                                        16'($urandom_range(0, 600)));
            endcase
            repeat (10)
            begin
                if ($urandom_range(99) < 85)
                    press_sequence();
                else
                    send_poll($urandom(), 3'($urandom_range(0, 7)));
            end
            wait_until_settled();
        end
    endtask

    task automatic test_output_stall();
        int target;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_thresholds(16'd50, 16'd120);
        target        = polls_sent + 60;
        stall_request = 300;
        while (polls_sent < target)
            press_sequence();
        wait_until_settled();
    endtask

    // receiver: random ready, with a long hold when asked
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request != 0)
            begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each word taken at the next edge with the oldest expectation
    always @(negedge clk)
    begin
        bpc_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected result, actual kind %0d button %0d",
                         $time, out_data.event_kind, out_data.event_button);
                error_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (out_data.event_kind !== want.event_kind)
                begin
                    $display("%0t: event_kind mismatch, expected %0d actual %0d",
                             $time, want.event_kind, out_data.event_kind);
                    error_count++;
                end
                if (out_data.event_button !== want.event_button)
                begin
                    $display("%0t: event_button mismatch, expected %0d actual %0d",
                             $time, want.event_button, out_data.event_button);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_LONG_PRESS;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_presses();
        test_threshold_extremes();
        test_random_polls(300, 17, 53);
        test_random_polls(300, 53, 17);
        test_random_polls(300, 0, 0);
        test_output_stall();

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
